### design/lrs_pkg.sv
// Shared types and constants for the link retry supervisor.
// No dependencies; imported by link_retry_supervisor.
package lrs_pkg;

    // Poll tick period in milliseconds
    localparam int unsigned POLL_MS = 1000;

    localparam int unsigned MS_W    = 20;
    localparam int unsigned FAIL_W  = 16;
    localparam int unsigned LIMIT_W = 8;
    localparam int unsigned BOOT_W  = 4;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned CFG_A_W = 3;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 48;

    typedef enum logic [1:0] {
        MODE_CONNECTING = 2'd0,
        MODE_ONLINE     = 2'd1,
        MODE_BACKOFF    = 2'd2
    } mode_t;

    typedef enum logic [OP_W-1:0] {
        OP_BOOT   = 2'd0,
        OP_RESULT = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] CFG_BACKOFF_FIRST  = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_BACKOFF_SECOND = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_BACKOFF_THIRD  = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_BACKOFF_FOURTH = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_BACKOFF_LAST   = 3'd4;
    localparam logic [CFG_A_W-1:0] CFG_FAILURE_LIMIT  = 3'd5;
    localparam logic [CFG_A_W-1:0] CFG_REBOOT_BUDGET  = 3'd6;

    localparam logic [MS_W-1:0]    RST_BACKOFF_FIRST  = 20'd5000;
    localparam logic [MS_W-1:0]    RST_BACKOFF_SECOND = 20'd10000;
    localparam logic [MS_W-1:0]    RST_BACKOFF_THIRD  = 20'd20000;
    localparam logic [MS_W-1:0]    RST_BACKOFF_FOURTH = 20'd40000;
    localparam logic [MS_W-1:0]    RST_BACKOFF_LAST   = 20'd60000;
    localparam logic [LIMIT_W-1:0] RST_FAILURE_LIMIT  = 8'd10;
    localparam logic [BOOT_W-1:0]  RST_REBOOT_BUDGET  = 4'd2;

    localparam logic [MS_W-1:0]   MS_MAX   = '1;
    localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

endpackage

### design/link_retry_supervisor.sv
// Link retry supervisor: mode, failure/reboot counters and backoff timer.
// Depends on lrs_pkg.
//
// Result word is registered: an accepted input word passes the input register, then
// the result register, which holds it while m_tready is low.
// Throughput: one word per cycle; a word is taken whenever the result register can move on.
// State update is a short compare/increment/select path between the two registers.
// Reset (aresetn low, synchronous): mode connecting, counters and timer zero,
// config registers at defaults, both pipeline stages empty.
module link_retry_supervisor (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write port
    input  logic                           cfg_wr_en,
    input  logic [lrs_pkg::CFG_A_W-1:0]    cfg_addr,
    input  logic [lrs_pkg::MS_W-1:0]       cfg_wdata,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // tdata: attempt_ok, link_up, settings_changed, reboot_allowed,
    //        software_reset, 3 zero bits
    input  logic [lrs_pkg::IN_DATA_W-1:0]  s_tdata,
    // tuser: op
    input  logic [lrs_pkg::OP_W-1:0]       s_tuser,
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tdata: mode_now[1:0], failure_count[17:2], reboot_count[21:18],
    //        reboot_flag[22], budget_exhausted[23], start_attempt[24],
    //        request_reboot[25], reboot_held[26], notify_online[27],
    //        backoff_ms[47:28]
    output logic [lrs_pkg::OUT_DATA_W-1:0] m_tdata
);
    import lrs_pkg::*;

    // config
    logic [MS_W-1:0]    bo_first_reg, bo_second_reg, bo_third_reg;
    logic [MS_W-1:0]    bo_fourth_reg, bo_last_reg;
    logic [LIMIT_W-1:0] fail_limit_reg;
    logic [BOOT_W-1:0]  budget_reg;

    // supervisor state
    mode_t              mode_reg, mode_next;
    logic [FAIL_W-1:0]  failures_reg, failures_next;
    logic [BOOT_W-1:0]  reboots_reg, reboots_next;
    logic [MS_W-1:0]    target_reg, target_next;
    logic [MS_W-1:0]    waited_reg, waited_next;

    // pipeline
    logic               in_valid_reg;
    op_t                op_reg;
    logic               ok_reg, link_reg, changed_reg, allowed_reg, swreset_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] result_reg, result_next;
    logic               advance;

    // decision terms
    logic               ev_boot, ev_result, ev_tick, ev_fail;
    logic [FAIL_W-1:0]  fail_inc;
    logic               at_limit, do_reboot, do_held, backoff_fail;
    logic [MS_W-1:0]    chosen;
    logic [MS_W:0]      wait_sum;
    logic [MS_W-1:0]    wait_sat;
    logic               backoff_done, online_drop;
    logic               start_pulse, online_pulse;
    logic               rebooted, exhausted;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bo_first_reg   <= RST_BACKOFF_FIRST;
            bo_second_reg  <= RST_BACKOFF_SECOND;
            bo_third_reg   <= RST_BACKOFF_THIRD;
            bo_fourth_reg  <= RST_BACKOFF_FOURTH;
            bo_last_reg    <= RST_BACKOFF_LAST;
            fail_limit_reg <= RST_FAILURE_LIMIT;
            budget_reg     <= RST_REBOOT_BUDGET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_BACKOFF_FIRST:  bo_first_reg   <= cfg_wdata;
                CFG_BACKOFF_SECOND: bo_second_reg  <= cfg_wdata;
                CFG_BACKOFF_THIRD:  bo_third_reg   <= cfg_wdata;
                CFG_BACKOFF_FOURTH: bo_fourth_reg  <= cfg_wdata;
                CFG_BACKOFF_LAST:   bo_last_reg    <= cfg_wdata;
                CFG_FAILURE_LIMIT:  fail_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                CFG_REBOOT_BUDGET:  budget_reg     <= cfg_wdata[BOOT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg      <= op_t'(s_tuser);
            ok_reg      <= s_tdata[0];
            link_reg    <= s_tdata[1];
            changed_reg <= s_tdata[2];
            allowed_reg <= s_tdata[3];
            swreset_reg <= s_tdata[4];
        end
    end

    // shared decision terms
    assign ev_boot   = (op_reg == OP_BOOT);
    assign ev_result = (op_reg == OP_RESULT) && (mode_reg == MODE_CONNECTING);
    assign ev_tick   = (op_reg == OP_TICK);
    assign ev_fail   = ev_result && !ok_reg;

    assign fail_inc  = (failures_reg == FAIL_MAX) ? failures_reg
                                                  : failures_reg + FAIL_W'(1);
    assign at_limit  = fail_inc >= {{(FAIL_W-LIMIT_W){1'b0}}, fail_limit_reg};
    assign do_reboot = ev_fail && at_limit && allowed_reg && (reboots_reg < budget_reg);
    assign do_held   = ev_fail && at_limit && !allowed_reg;
    assign backoff_fail = ev_fail && !do_reboot;

    // backoff step: index is count-1 capped at the last entry
    always_comb begin
        case (fail_inc)
            FAIL_W'(1): chosen = bo_first_reg;
            FAIL_W'(2): chosen = bo_second_reg;
            FAIL_W'(3): chosen = bo_third_reg;
            FAIL_W'(4): chosen = bo_fourth_reg;
            default:    chosen = bo_last_reg;
        endcase
    end

    assign wait_sum = {1'b0, waited_reg} + (MS_W+1)'(POLL_MS);
    assign wait_sat = wait_sum[MS_W] ? MS_MAX : wait_sum[MS_W-1:0];

    assign backoff_done = ev_tick && (mode_reg == MODE_BACKOFF) &&
                          (changed_reg || (wait_sat >= target_reg));
    assign online_drop  = ev_tick && (mode_reg == MODE_ONLINE) &&
                          (changed_reg || !link_reg);

    // next state
    always_comb begin
        mode_next     = mode_reg;
        failures_next = failures_reg;
        reboots_next  = reboots_reg;
        target_next   = target_reg;
        waited_next   = waited_reg;
        if (ev_boot) begin
            if (!swreset_reg) begin
                reboots_next = '0;
            end
            mode_next     = MODE_CONNECTING;
            failures_next = '0;
            target_next   = '0;
            waited_next   = '0;
        end else if (ev_result && ok_reg) begin
            failures_next = '0;
            reboots_next  = '0;
            mode_next     = MODE_ONLINE;
        end else if (ev_fail) begin
            failures_next = fail_inc;
            waited_next   = '0;
            if (do_reboot) begin
                reboots_next = reboots_reg + BOOT_W'(1);
                mode_next    = MODE_CONNECTING;
                target_next  = '0;
            end else begin
                target_next = chosen;
                mode_next   = (chosen == '0) ? MODE_CONNECTING : MODE_BACKOFF;
            end
        end else if (ev_tick && (mode_reg == MODE_BACKOFF)) begin
            if (!changed_reg) begin
                waited_next = wait_sat;
            end
            if (backoff_done) begin
                mode_next   = MODE_CONNECTING;
                waited_next = '0;
            end
        end else if (online_drop) begin
            mode_next = MODE_CONNECTING;
        end
    end

    // result word; status reflects the state after this word
    always_comb begin
        start_pulse  = ev_boot || (backoff_fail && (chosen == '0)) ||
                       backoff_done || online_drop;
        online_pulse = ev_result && ok_reg;
        rebooted     = (reboots_next != '0);
        exhausted    = (reboots_next >= budget_reg) &&
                       (failures_next >= {{(FAIL_W-LIMIT_W){1'b0}}, fail_limit_reg});
        result_next  = {backoff_fail ? chosen : {MS_W{1'b0}},
                        online_pulse, do_held, do_reboot, start_pulse,
                        exhausted, rebooted, reboots_next, failures_next,
                        mode_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_CONNECTING;
            failures_reg  <= '0;
            reboots_reg   <= '0;
            target_reg    <= '0;
            waited_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                mode_reg     <= mode_next;
                failures_reg <= failures_next;
                reboots_reg  <= reboots_next;
                target_reg   <= target_next;
                waited_reg   <= waited_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

endmodule
